// File: src/lvpd_pkg.sv
// Package: shared types and constants for the label/value packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package lvpd_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam logic [8:0]  MAX_ELEMENTS = 9'd255;
    localparam logic [15:0] ID_LIMIT_RESET = 16'd16;

    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_SOH      = 8'h01;
    localparam logic [7:0] CH_STX      = 8'h02;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_BAR      = 8'h7C;

    typedef enum logic [2:0] {
        ROLE_SIZE     = 3'd0,
        ROLE_ID       = 3'd1,
        ROLE_LABEL    = 3'd2,
        ROLE_COLON    = 3'd3,
        ROLE_ENCODING = 3'd4,
        ROLE_DATA     = 3'd5,
        ROLE_BAR      = 3'd6
    } role_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BAD_BYTE = 3'd2,
        ST_BAD_ID   = 3'd3,
        ST_TRUNC    = 3'd4,
        ST_TOO_MANY = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_LABEL_EMPTY = 2'd0,
        PH_LABEL       = 2'd1,
        PH_ENCODING    = 2'd2,
        PH_DATA        = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]         byte_out;
        role_t              role;
        logic [7:0]         element_index;
        logic               packet_end;
        status_t            status;
        logic [31:0]        frame_size;
        logic signed [31:0] frame_id;
        logic [7:0]         element_count;
    } result_t;

endpackage

`default_nettype wire

// File: src/lvpd_if.sv
// Interfaces: byte input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none

interface lvpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       final_byte;

    modport source (output valid, output rx_byte, output final_byte, input ready);
    modport sink   (input valid, input rx_byte, input final_byte, output ready);
endinterface

interface lvpd_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         byte_out;
    logic [2:0]         role;
    logic [7:0]         element_index;
    logic               packet_end;
    logic [2:0]         status;
    logic [31:0]        frame_size;
    logic signed [31:0] frame_id;
    logic [7:0]         element_count;

    modport source (output valid, output byte_out, output role, output element_index,
                    output packet_end, output status, output frame_size,
                    output frame_id, output element_count, input ready);
    modport sink   (input valid, input byte_out, input role, input element_index,
                    input packet_end, input status, input frame_size,
                    input frame_id, input element_count, output ready);
endinterface

`default_nettype wire

// File: src/lvpd_parse.sv
// Parser: header assembly, body phase tracking, checks and per-byte result.
`timescale 1ns / 1ps
`default_nettype none

module lvpd_parse
    import lvpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        final_byte,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    output result_t          result
);

    logic [15:0] id_limit_reg;
    logic [3:0]  header_count_reg, header_count_next;
    logic [31:0] size_word_reg, size_word_next;
    logic [31:0] id_word_reg, id_word_next;
    phase_t      phase_reg, phase_next;
    logic [8:0]  closed_reg, closed_next;
    logic        bad_seen_reg, bad_seen_next;

    logic        in_header;
    logic        byte_bad;
    logic [7:0]  closed_sat;
    logic [7:0]  count_sat;
    status_t     status;
    role_t       role;

    assign in_header  = (header_count_reg < 4'(HEADER_BYTES));
    assign closed_sat = closed_reg[8] ? 8'hFF : closed_reg[7:0];
    assign count_sat  = closed_next[8] ? 8'hFF : closed_next[7:0];

    always_comb
    begin
        byte_bad = !(rx_byte >= CH_PRINT_LO && rx_byte <= CH_PRINT_HI)
                   && !(rx_byte inside {CH_NUL, CH_SOH, CH_STX, CH_LF});
    end

    always_comb
    begin
        header_count_next = header_count_reg;
        size_word_next    = size_word_reg;
        id_word_next      = id_word_reg;
        phase_next        = phase_reg;
        closed_next       = closed_reg;
        bad_seen_next     = bad_seen_reg;
        role              = ROLE_SIZE;

        if (in_header)
        begin
            if (!header_count_reg[2])
            begin
                role = ROLE_SIZE;
                size_word_next[{header_count_reg[1:0], 3'b000} +: 8] = rx_byte;
            end
            else
            begin
                role = ROLE_ID;
                id_word_next[{header_count_reg[1:0], 3'b000} +: 8] = rx_byte;
            end
            header_count_next = header_count_reg + 4'd1;
        end
        else
        begin
            if (byte_bad)
            begin
                bad_seen_next = 1'b1;
            end
            case (phase_reg)
                PH_LABEL_EMPTY, PH_LABEL:
                begin
                    if (rx_byte == CH_COLON)
                    begin
                        role       = ROLE_COLON;
                        phase_next = PH_ENCODING;
                    end
                    else
                    begin
                        role       = ROLE_LABEL;
                        phase_next = PH_LABEL;
                    end
                end
                PH_ENCODING:
                begin
                    role       = ROLE_ENCODING;
                    phase_next = PH_DATA;
                end
                default:
                begin
                    if (rx_byte == CH_BAR)
                    begin
                        role       = ROLE_BAR;
                        phase_next = PH_LABEL_EMPTY;
                        // hold the count one past the limit
                        if (closed_reg <= MAX_ELEMENTS)
                        begin
                            closed_next = closed_reg + 9'd1;
                        end
                    end
                    else
                    begin
                        role = ROLE_DATA;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        if (header_count_next < 4'(HEADER_BYTES))
        begin
            status = ST_SHORT;
        end
        else if (bad_seen_next)
        begin
            status = ST_BAD_BYTE;
        end
        else if (!id_word_next[31] && id_word_next >= {16'd0, id_limit_reg})
        begin
            status = ST_BAD_ID;
        end
        else if (phase_next == PH_LABEL || phase_next == PH_ENCODING)
        begin
            status = ST_TRUNC;
        end
        else if (closed_next > MAX_ELEMENTS)
        begin
            status = ST_TOO_MANY;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        result.byte_out      = rx_byte;
        result.role          = role;
        result.element_index = in_header ? 8'd0 : closed_sat;
        result.packet_end    = final_byte;
        if (final_byte)
        begin
            result.status        = status;
            result.frame_size    = size_word_next;
            result.frame_id      = id_word_next;
            result.element_count = count_sat;
        end
        else
        begin
            result.status        = ST_OK;
            result.frame_size    = 32'd0;
            result.frame_id      = 32'sd0;
            result.element_count = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_limit_reg <= ID_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            id_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg <= 4'd0;
            size_word_reg    <= 32'd0;
            id_word_reg      <= 32'd0;
            phase_reg        <= PH_LABEL_EMPTY;
            closed_reg       <= 9'd0;
            bad_seen_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (final_byte)
            begin
                // drop all packet state, ready for the next packet
                header_count_reg <= 4'd0;
                size_word_reg    <= 32'd0;
                id_word_reg      <= 32'd0;
                phase_reg        <= PH_LABEL_EMPTY;
                closed_reg       <= 9'd0;
                bad_seen_reg     <= 1'b0;
            end
            else
            begin
                header_count_reg <= header_count_next;
                size_word_reg    <= size_word_next;
                id_word_reg      <= id_word_next;
                phase_reg        <= phase_next;
                closed_reg       <= closed_next;
                bad_seen_reg     <= bad_seen_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/lvpd_outbuf.sv
// Result register with a skid stage between parser and output channel.
`timescale 1ns / 1ps
`default_nettype none

module lvpd_outbuf
    import lvpd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    accept;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (out_ready || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = in_data;
                main_valid_next = accept;
            end
        end
        else if (accept)
        begin
            // output stalled: park the new transaction
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

// File: src/label_value_packet_deframer_core.sv
// Top level: label/value packet deframer, byte in, tagged result out.
`timescale 1ns / 1ps
`default_nettype none

// Takes one packet byte per transaction on bytes (final_byte marks the last) and
// returns one result per byte on results: the byte, its role (size word, id word,
// label, colon, encoding, data, bar) and its element index. The result for the
// final byte also carries the size and id header words, the closed element count
// and a status; the block then starts afresh on the next packet. A byte is taken
// every clock while the skid stage is empty; the parser state and the output (or
// skid) register update in the same cycle, and the skid stage keeps input open for
// one more transaction while the output is stalled. id_limit (cfg_we/cfg_wdata)
// resets to 16; the user must write it between packets; the block does not enforce it.
module label_value_packet_deframer_core
    import lvpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    lvpd_in_if.sink          bytes,
    lvpd_out_if.source       results,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    result_t parsed;
    result_t buffered;
    logic    accept;

    assign accept = bytes.valid && bytes.ready;

    lvpd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (bytes.rx_byte),
        .final_byte (bytes.final_byte),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .result     (parsed)
    );

    lvpd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bytes.valid),
        .in_ready  (bytes.ready),
        .in_data   (parsed),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (buffered)
    );

    assign results.byte_out      = buffered.byte_out;
    assign results.role          = buffered.role;
    assign results.element_index = buffered.element_index;
    assign results.packet_end    = buffered.packet_end;
    assign results.status        = buffered.status;
    assign results.frame_size    = buffered.frame_size;
    assign results.frame_id      = buffered.frame_id;
    assign results.element_count = buffered.element_count;

endmodule

`default_nettype wire

// File: test/tb_label_value_packet_deframer_core.sv
// Testbench: label/value packet deframer, random and directed packets against a predictor.
`timescale 1ns / 1ps

module tb_label_value_packet_deframer_core
    import lvpd_pkg::*;
;

    localparam int RANDOM_BYTES   = 320;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int BIG_ELEMENTS   = 256;

    // Tracks packet state byte by byte and holds the tagged results still owed.
    class deframe_tracker;
        logic [15:0] id_lim;
        int unsigned hdr_seen;
        logic [31:0] size_acc;
        logic [31:0] id_acc;
        phase_t      phase;
        logic [8:0]  closed_cnt;
        bit          saw_junk;
        result_t     pending[$];
        int          mismatches;
        int          endings[6];

        function new();
            id_lim = ID_LIMIT_RESET;
            mismatches = 0;
            foreach (endings[i]) endings[i] = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            hdr_seen = 0;
            size_acc = '0;
            id_acc = '0;
            phase = PH_LABEL_EMPTY;
            closed_cnt = '0;
            saw_junk = 1'b0;
        endfunction

        function void take_byte(logic [7:0] b, logic fin);
            result_t r;
            r = '0;
            r.byte_out = b;
            r.packet_end = fin;
            if (hdr_seen < HEADER_BYTES) begin
                if (hdr_seen < 4) begin
                    r.role = ROLE_SIZE;
                    size_acc[8*(hdr_seen%4) +: 8] = b;
                end else begin
                    r.role = ROLE_ID;
                    id_acc[8*(hdr_seen%4) +: 8] = b;
                end
                hdr_seen++;
            end else begin
                r.element_index = closed_cnt[8] ? 8'hFF : closed_cnt[7:0];
                if (!((b >= CH_PRINT_LO && b <= CH_PRINT_HI) || b == CH_NUL ||
                      b == CH_SOH || b == CH_STX || b == CH_LF))
                    saw_junk = 1'b1;
                case (phase)
                    PH_LABEL_EMPTY, PH_LABEL: begin
                        if (b == CH_COLON) begin
                            r.role = ROLE_COLON;
                            phase = PH_ENCODING;
                        end else begin
                            r.role = ROLE_LABEL;
                            phase = PH_LABEL;
                        end
                    end
                    PH_ENCODING: begin
                        r.role = ROLE_ENCODING;
                        phase = PH_DATA;
                    end
                    default: begin
                        if (b == CH_BAR) begin
                            r.role = ROLE_BAR;
                            phase = PH_LABEL_EMPTY;
                            // hold one past the limit so the overflow is remembered
                            if (closed_cnt <= MAX_ELEMENTS)
                                closed_cnt++;
                        end else begin
                            r.role = ROLE_DATA;
                        end
                    end
                endcase
            end
            if (fin) begin
                if (hdr_seen < HEADER_BYTES)
                    r.status = ST_SHORT;
                else if (saw_junk)
                    r.status = ST_BAD_BYTE;
                else if (!id_acc[31] && id_acc >= {16'd0, id_lim})
                    r.status = ST_BAD_ID;
                else if (phase == PH_LABEL || phase == PH_ENCODING)
                    r.status = ST_TRUNC;
                else if (closed_cnt > MAX_ELEMENTS)
                    r.status = ST_TOO_MANY;
                else
                    r.status = ST_OK;
                r.frame_size = size_acc;
                r.frame_id = id_acc;
                r.element_count = closed_cnt[8] ? 8'hFF : closed_cnt[7:0];
                endings[r.status]++;
                clear_packet();
            end
            pending.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual byte %h role %0d end %0b",
                         $time, got.byte_out, got.role, got.packet_end);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            check_field("byte_out", want.byte_out, got.byte_out);
            check_field("role", want.role, got.role);
            check_field("element_index", want.element_index, got.element_index);
            check_field("packet_end", want.packet_end, got.packet_end);
            check_field("status", want.status, got.status);
            check_field("frame_size", want.frame_size, got.frame_size);
            check_field("frame_id", want.frame_id, got.frame_id);
            check_field("element_count", want.element_count, got.element_count);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    lvpd_in_if  in_ch ();
    lvpd_out_if out_ch ();

    deframe_tracker tracker;
    logic [7:0]     frame_bytes[$];
    int             send_idle_pct;
    int             recv_stall_pct;
    int             quiet_cycles;
    int             bytes_sent;
    int             frames_sent;

    label_value_packet_deframer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (in_ch),
        .results   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both channels at the edge; inputs are noted before results are matched.
    initial begin : channel_monitor
        result_t got;
        bit      in_acc;
        bit      out_acc;
        quiet_cycles = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            in_acc = rst_n && in_ch.valid && in_ch.ready;
            out_acc = rst_n && out_ch.valid && out_ch.ready;
            if (in_acc)
                tracker.take_byte(in_ch.rx_byte, in_ch.final_byte);
            if (out_acc) begin
                got.byte_out = out_ch.byte_out;
                got.role = role_t'(out_ch.role);
                got.element_index = out_ch.element_index;
                got.packet_end = out_ch.packet_end;
                got.status = status_t'(out_ch.status);
                got.frame_size = out_ch.frame_size;
                got.frame_id = out_ch.frame_id;
                got.element_count = out_ch.element_count;
                tracker.match_result(got);
            end
            quiet_cycles = (in_acc || out_acc) ? 0 : quiet_cycles + 1;
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while ((b >= CH_PRINT_LO && b <= CH_PRINT_HI) || b == CH_NUL || b == CH_SOH ||
               b == CH_STX || b == CH_LF);
        return b;
    endfunction

    // Printable or one of the tolerated control bytes, never the given delimiter.
    function automatic logic [7:0] clean_byte(input logic [7:0] avoid);
        logic [7:0] b;
        do begin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: b = CH_NUL;
                    1: b = CH_SOH;
                    2: b = CH_STX;
                    default: b = CH_LF;
                endcase
            end else begin
                b = 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
            end
        end while (b == avoid);
        return b;
    endfunction

    function automatic logic [7:0] encoding_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 8'($urandom);
        else if (pick == 1)
            return CH_COLON;
        else if (pick == 2)
            return CH_BAR;
        return 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
    endfunction

    function automatic logic [31:0] pick_id(input logic [15:0] lim);
        int pick;
        pick = $urandom_range(99);
        if (pick < 60 && lim != 0)
            return 32'($urandom_range(lim - 1, 0));
        else if (pick < 75)
            return {1'b1, 31'($urandom)};
        else if (pick < 85)
            return {16'd0, lim};
        return $urandom;
    endfunction

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            frame_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic push_element(input int label_len, input int data_len, input bit close);
        repeat (label_len) frame_bytes.push_back(clean_byte(CH_COLON));
        frame_bytes.push_back(CH_COLON);
        frame_bytes.push_back(encoding_byte());
        repeat (data_len) frame_bytes.push_back(clean_byte(CH_BAR));
        if (close)
            frame_bytes.push_back(CH_BAR);
    endtask

    task automatic make_random_frame();
        int          kind;
        int          ending;
        logic [31:0] size_word;
        frame_bytes.delete();
        kind = $urandom_range(99);
        // noise and short packets
        if (kind < 13) begin
            repeat ((kind < 8) ? $urandom_range(20, 1) : $urandom_range(7, 1))
                frame_bytes.push_back(8'($urandom));
            return;
        end
        case ($urandom_range(3))
            0: size_word = '0;
            1: size_word = '1;
            default: size_word = $urandom;
        endcase
        push_word(size_word);
        push_word(pick_id(tracker.id_lim));
        if (kind < 18)
            return;
        repeat ($urandom_range(6, 0))
            push_element($urandom_range(4, 0), $urandom_range(5, 0), 1'b1);
        ending = $urandom_range(99);
        if (ending >= 86)
            push_element($urandom_range(3, 0), $urandom_range(3, 0), 1'b0);
        else if (ending >= 78)
            begin
                repeat ($urandom_range(3, 0)) frame_bytes.push_back(clean_byte(CH_COLON));
                frame_bytes.push_back(CH_COLON);
            end
        else if (ending >= 65)
            repeat ($urandom_range(3, 1)) frame_bytes.push_back(clean_byte(CH_COLON));
        if (frame_bytes.size() > HEADER_BYTES && $urandom_range(99) < 8)
            frame_bytes[$urandom_range(frame_bytes.size() - 1, HEADER_BYTES)] = junk_byte();
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            in_ch.rx_byte <= 8'($urandom);
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= b;
        in_ch.final_byte <= fin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        bytes_sent += frame_bytes.size();
        frames_sent++;
    endtask

    // Drop valid and wait until every owed result is back and the pipeline is empty.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_id_limit(input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.id_lim = value;
    endtask

    initial begin : stimulus
        logic [15:0] limits[6];
        int          random_bytes;
        tracker = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        bytes_sent = 0;
        frames_sent = 0;
        random_bytes = 0;
        limits = '{ID_LIMIT_RESET, 16'd0, 16'hFFFF, 16'($urandom), 16'd1, 16'd40};
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.rx_byte <= '0;
        in_ch.final_byte <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin send_idle_pct = 7;  recv_stall_pct = 86; end
                1: begin send_idle_pct = 86; recv_stall_pct = 7;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // first phase runs on the reset value of the id limit
            if (ph > 0)
                write_id_limit(limits[ph]);
            if (ph == 0) begin
                // short packet with extreme header bytes
                frame_bytes = '{8'hFF, 8'h00};
                send_frame();
                // id equal to the limit outranks the packet ending after a colon
                frame_bytes.delete();
                push_word(32'h0000_0000);
                push_word({16'd0, ID_LIMIT_RESET});
                frame_bytes.push_back(CH_COLON);
                send_frame();
                // junk in the header is ignored, junk in the body is not; bar as encoding
                frame_bytes.delete();
                push_word(32'hFFFF_FFFF);
                push_word(32'h8000_0000);
                frame_bytes.push_back(CH_COLON);
                frame_bytes.push_back(CH_BAR);
                frame_bytes.push_back(CH_NUL);
                frame_bytes.push_back(8'h80);
                frame_bytes.push_back(CH_BAR);
                send_frame();
            end
            if (ph == 2) begin
                // overflow the element count, then end inside an open data run
                frame_bytes.delete();
                push_word($urandom);
                push_word(32'd0);
                repeat (BIG_ELEMENTS) push_element(0, 0, 1'b1);
                push_element(0, 1, 1'b0);
                send_frame();
            end
            while (random_bytes < (ph + 1) * RANDOM_BYTES / 6) begin
                make_random_frame();
                send_frame();
                random_bytes += frame_bytes.size();
            end
            drain();
        end

        $display("Sent %0d bytes in %0d packets across six id_limit settings and idle mixes.",
                 bytes_sent, frames_sent);
        $display("Endings: ok %0d, short %0d, bad byte %0d, bad id %0d, truncated %0d, over %0d.",
                 tracker.endings[ST_OK], tracker.endings[ST_SHORT],
                 tracker.endings[ST_BAD_BYTE], tracker.endings[ST_BAD_ID],
                 tracker.endings[ST_TRUNC], tracker.endings[ST_TOO_MANY]);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
